/* hdl/skct_pkg.sv */
package skct_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int KEY_BITS    = 64;
    localparam int COUNT_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int LEN_BITS    = $clog2(TABLE_DEPTH + 1);

    localparam logic [0:0] OP_ADD  = 1'b0;
    localparam logic [0:0] OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_READ_OK   = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_DECIDE_RD,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_READ_RD,
        S_READ_DONE,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic init_search;
        logic rd_mid;
        logic step_search;
        logic rd_pos;
        logic do_update;
        logic do_full;
        logic init_shift;
        logic rd_shift;
        logic wr_shift;
        logic do_insert;
        logic rd_index;
        logic do_read;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic search_done;
        logic key_match;
        logic is_full;
        logic shift_done;
        logic index_ok;
    } dp_status_t;

endpackage

/* hdl/skct_datapath.sv */
module skct_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  skct_pkg::dp_cmd_t                 cmd,
    output skct_pkg::dp_status_t              stat,
    input  logic                              op,
    input  logic [63:0]                       key,
    input  logic [31:0]                       increment,
    input  logic [15:0]                       read_index,
    output logic [63:0]                       entry_key,
    output logic [31:0]                       entry_count,
    output logic [15:0]                       entry_position,
    output logic [16:0]                       fill_length,
    output logic [2:0]                        status
);

    localparam int AB = skct_pkg::ADDR_BITS;
    localparam int LB = skct_pkg::LEN_BITS;
    localparam int KB = skct_pkg::KEY_BITS;
    localparam int CB = skct_pkg::COUNT_BITS;

    // table memories, one port each way
    logic [KB-1:0] key_mem   [skct_pkg::TABLE_DEPTH];
    logic [CB-1:0] count_mem [skct_pkg::TABLE_DEPTH];

    logic [KB-1:0] rd_key_reg;
    logic [CB-1:0] rd_count_reg;

    logic          op_reg;
    logic [KB-1:0] key_reg;
    logic [31:0]   inc_reg;
    logic [15:0]   idx_reg;
    logic [LB-1:0] held_reg,  held_next;
    logic [LB-1:0] lo_reg,    lo_next;
    logic [LB-1:0] hi_reg,    hi_next;
    logic [LB-1:0] ptr_reg,   ptr_next;
    logic [KB-1:0] res_key_reg;
    logic [CB-1:0] res_count_reg;
    logic [LB-1:0] res_pos_reg;
    skct_pkg::status_t res_status_reg;

    logic [LB-1:0] mid;
    logic [AB-1:0] rd_addr;
    logic          wr_en;
    logic [AB-1:0] wr_addr;
    logic [KB-1:0] wr_key;
    logic [CB-1:0] wr_count;
    logic [CB:0]   sum;
    logic [CB-1:0] sat_sum;
    logic [CB-1:0] sat_inc;
    logic [LB-1:0] idx_ext;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sum = {1'b0, rd_count_reg} + (CB+1)'(inc_reg);
    assign sat_sum = sum[CB] ? {CB{1'b1}} : sum[CB-1:0];
    assign sat_inc = (CB >= 32) ? CB'(inc_reg)
                   : ((inc_reg > 32'({CB{1'b1}})) ? {CB{1'b1}} : CB'(inc_reg));
    assign idx_ext = LB'(idx_reg);

    always_comb
    begin
        rd_addr = mid[AB-1:0];
        if (cmd.rd_pos)
        begin
            rd_addr = lo_reg[AB-1:0];
        end
        else if (cmd.rd_shift)
        begin
            rd_addr = AB'(ptr_reg - LB'(1));
        end
        else if (cmd.rd_index)
        begin
            rd_addr = idx_ext[AB-1:0];
        end
    end

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = lo_reg[AB-1:0];
        wr_key   = key_reg;
        wr_count = sat_inc;
        if (cmd.do_update)
        begin
            wr_en    = 1'b1;
            wr_count = sat_sum;
        end
        else if (cmd.wr_shift)
        begin
            wr_en    = 1'b1;
            wr_addr  = ptr_reg[AB-1:0];
            wr_key   = rd_key_reg;
            wr_count = rd_count_reg;
        end
        else if (cmd.do_insert)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            count_mem[wr_addr] <= wr_count;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_count_reg <= count_mem[rd_addr];
    end

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.init_search)
        begin
            lo_next = '0;
            hi_next = held_reg;
        end
        else if (cmd.step_search)
        begin
            if (rd_key_reg < key_reg)
            begin
                lo_next = mid + LB'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.init_shift)
        begin
            ptr_next = held_reg;
        end
        else if (cmd.wr_shift)
        begin
            ptr_next = ptr_reg - LB'(1);
        end
    end

    assign held_next = cmd.do_insert ? held_reg + LB'(1) : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        ptr_reg <= ptr_next;
        if (cmd.load_item)
        begin
            op_reg  <= op;
            key_reg <= key[KB-1:0];
            inc_reg <= increment;
            idx_reg <= read_index;
        end
        if (cmd.do_update)
        begin
            res_key_reg    <= key_reg;
            res_count_reg  <= sat_sum;
            res_pos_reg    <= lo_reg;
            res_status_reg <= skct_pkg::ST_UPDATED;
        end
        else if (cmd.do_full)
        begin
            res_key_reg    <= key_reg;
            res_count_reg  <= '0;
            res_pos_reg    <= '0;
            res_status_reg <= skct_pkg::ST_FULL;
        end
        else if (cmd.do_insert)
        begin
            res_key_reg    <= key_reg;
            res_count_reg  <= sat_inc;
            res_pos_reg    <= lo_reg;
            res_status_reg <= skct_pkg::ST_INSERTED;
        end
        else if (cmd.do_read)
        begin
            if (stat.index_ok)
            begin
                res_key_reg    <= rd_key_reg;
                res_count_reg  <= rd_count_reg;
                res_pos_reg    <= idx_ext;
                res_status_reg <= skct_pkg::ST_READ_OK;
            end
            else
            begin
                res_key_reg    <= '0;
                res_count_reg  <= '0;
                res_pos_reg    <= '0;
                res_status_reg <= skct_pkg::ST_BAD_INDEX;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            entry_key      <= 64'(res_key_reg);
            entry_count    <= res_count_reg[31:0];
            entry_position <= 16'(res_pos_reg);
            fill_length    <= 17'(held_reg);
            status         <= res_status_reg;
        end
    end

    assign stat.is_read     = op_reg == skct_pkg::OP_READ;
    assign stat.search_done = lo_reg == hi_reg;
    assign stat.key_match   = (lo_reg < held_reg) && (rd_key_reg == key_reg);
    assign stat.is_full     = held_reg == LB'(skct_pkg::TABLE_DEPTH);
    assign stat.shift_done  = ptr_reg == lo_reg;
    assign stat.index_ok    = (LB+16)'(idx_reg) < (LB+16)'(held_reg);

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= LB'(skct_pkg::TABLE_DEPTH))
        else $error("fill length beyond depth");
    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg || cmd.init_search || $past(cmd.init_search) == 1'b0)
        else $error("search bounds crossed");
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> held_reg == $past(held_reg) + LB'(1))
        else $error("insert did not grow table");
    a_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.do_insert |=> $stable(held_reg))
        else $error("fill length changed without insert");
`endif

endmodule

/* hdl/skct_ctrl.sv */
module skct_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  skct_pkg::dp_status_t stat,
    output skct_pkg::dp_cmd_t    cmd
);

    skct_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic busy;

    assign busy = state_reg != skct_pkg::S_IDLE;
    // the output word may still wait while a new item is taken
    assign in_stall  = busy;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skct_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = skct_pkg::S_SEARCH_RD;
                end
            end
            skct_pkg::S_SEARCH_RD:
            begin
                if (stat.is_read)
                begin
                    state_next = skct_pkg::S_READ_RD;
                end
                else if (stat.search_done)
                begin
                    state_next = skct_pkg::S_DECIDE_RD;
                end
                else
                begin
                    state_next = skct_pkg::S_SEARCH_CMP;
                end
            end
            skct_pkg::S_SEARCH_CMP: state_next = skct_pkg::S_SEARCH_RD;
            skct_pkg::S_DECIDE_RD:  state_next = skct_pkg::S_DECIDE;
            skct_pkg::S_DECIDE:
            begin
                if (stat.key_match || stat.is_full)
                begin
                    state_next = skct_pkg::S_OUT;
                end
                else
                begin
                    state_next = skct_pkg::S_SHIFT_RD;
                end
            end
            // shift pointer is valid here, in the cycle after it is set up
            skct_pkg::S_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    state_next = skct_pkg::S_INSERT;
                end
                else
                begin
                    state_next = skct_pkg::S_SHIFT_WR;
                end
            end
            skct_pkg::S_SHIFT_WR:   state_next = skct_pkg::S_SHIFT_RD;
            skct_pkg::S_INSERT:     state_next = skct_pkg::S_OUT;
            skct_pkg::S_READ_RD:    state_next = skct_pkg::S_READ_DONE;
            skct_pkg::S_READ_DONE:  state_next = skct_pkg::S_OUT;
            skct_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = skct_pkg::S_IDLE;
                end
            end
            default:                state_next = skct_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            skct_pkg::S_IDLE:       cmd.load_item = in_valid;
            skct_pkg::S_SEARCH_RD:  cmd.rd_mid = 1'b1;
            skct_pkg::S_SEARCH_CMP: cmd.step_search = 1'b1;
            skct_pkg::S_DECIDE_RD:  cmd.rd_pos = 1'b1;
            skct_pkg::S_DECIDE:
            begin
                cmd.do_update  = stat.key_match;
                cmd.do_full    = !stat.key_match && stat.is_full;
                cmd.init_shift = !stat.key_match && !stat.is_full;
            end
            skct_pkg::S_SHIFT_RD:   cmd.rd_shift = !stat.shift_done;
            skct_pkg::S_SHIFT_WR:   cmd.wr_shift = 1'b1;
            skct_pkg::S_INSERT:     cmd.do_insert = 1'b1;
            skct_pkg::S_READ_RD:    cmd.rd_index = 1'b1;
            skct_pkg::S_READ_DONE:  cmd.do_read = 1'b1;
            skct_pkg::S_OUT:        cmd.out_load = !out_valid_reg || !out_stall;
            default:                cmd = '0;
        endcase
        // search bounds are set up as the item is taken
        cmd.init_search = cmd.load_item;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skct_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |-> state_reg == skct_pkg::S_IDLE)
        else $error("item taken while busy");
    a_out_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output word overwritten");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.do_update, cmd.wr_shift, cmd.do_insert}) <= 1)
        else $error("two table writes at once");
`endif

endmodule

/* hdl/sorted_key_count_table_core.sv */
// sorted key/count histogram table
// input channel: in_valid/in_stall with op, key, increment, read_index;
//   op add looks up key by binary search and adds increment to its count
//   (saturating), or inserts the key at its sorted place; op read returns
//   the entry at read_index
// output channel: out_valid/out_stall with entry_key, entry_count,
//   entry_position, fill_length, status; one word per input word
// one item at a time; the binary search takes about log2(fill+1)
//   halvings, each one memory read and one compare; an add then updates
//   the matched entry, drops the key if the table is full, or moves the
//   entries above the place up one by one (a read and a write each, through
//   the single read and write port) and inserts; a read does one table read
// the next item is taken in the cycle after the word is registered
// the table memory is not cleared: only entries below the fill length are
//   ever used in a result; reset only empties the fill length and the control state
// if the receiver stalls, the finished word waits in the output register and
//   the next item is processed; its result waits until the register frees
module sorted_key_count_table_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [63:0] key,
    input  logic [31:0] increment,
    input  logic [15:0] read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] entry_key,
    output logic [31:0] entry_count,
    output logic [15:0] entry_position,
    output logic [16:0] fill_length,
    output logic [2:0]  status
);

    skct_pkg::dp_cmd_t    cmd;
    skct_pkg::dp_status_t stat;

    // sequencer
    skct_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table memory, search bounds and result registers
    skct_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .key            (key),
        .increment      (increment),
        .read_index     (read_index),
        .entry_key      (entry_key),
        .entry_count    (entry_count),
        .entry_position (entry_position),
        .fill_length    (fill_length),
        .status         (status)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entry_key))
        else $error("stalled word changed");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken at once");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'd4)
        else $error("bad status code");
`endif

endmodule
